@@ rtl/core/triangle_transform_cull_snap_defines.svh @@
// Assertion macros for the triangle transform block
`ifndef TRIANGLE_TRANSFORM_CULL_SNAP_DEFINES_SVH
`define TRIANGLE_TRANSFORM_CULL_SNAP_DEFINES_SVH

// same-cycle implication
`define TTCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ttcs check failed");

// next-cycle implication
`define TTCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ttcs check failed");

`endif

@@ rtl/core/ttcs_pkg.sv @@
package ttcs_pkg;

    localparam int VIEW_W     = 320;
    localparam int VIEW_H     = 240;
    localparam int SNAP_SHIFT = 2;
    localparam int SNAP_STEP  = 1 << SNAP_SHIFT;

    localparam int T_W   = 22;
    localparam int Q_W   = 16;
    localparam int N_W   = 32;
    localparam int RC_W  = 26;
    localparam int IS_W  = 11;
    localparam int SZ_W  = 13;
    localparam int LAT   = 6;

    localparam logic [IS_W-1:0] ISZ_X = IS_W'(VIEW_W);
    localparam logic [IS_W-1:0] ISZ_Y = IS_W'(VIEW_H);
    localparam logic [RC_W-1:0] RECIP_X =
        RC_W'(((64'd1 << 32) + VIEW_W - 1) / VIEW_W);
    localparam logic [RC_W-1:0] RECIP_Y =
        RC_W'(((64'd1 << 32) + VIEW_H - 1) / VIEW_H);

    localparam logic [23:0] RGB_MASK = 24'hF8F8F8;

    localparam logic [2:0] REG_ROW_X  = 3'd0;
    localparam logic [2:0] REG_ROW_Y  = 3'd1;
    localparam logic [2:0] REG_ROW_Z  = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] c_x;
        logic signed [15:0] c_y;
        logic signed [15:0] c_z;
        logic [23:0]        rgb_in;
    } t_tri_in;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] sa_x;
        logic signed [15:0] sa_y;
        logic signed [15:0] sa_z;
        logic signed [15:0] sb_x;
        logic signed [15:0] sb_y;
        logic signed [15:0] sb_z;
        logic signed [15:0] sc_x;
        logic signed [15:0] sc_y;
        logic signed [15:0] sc_z;
        logic [23:0]        rgb_out;
    } t_tri_out;

    typedef struct packed {
        logic signed [T_W-1:0] tx;
        logic signed [T_W-1:0] ty;
    } t_vtx_xy;

    function automatic logic signed [15:0] sat16(input logic signed [N_W-1:0] v);
        logic signed [15:0] r;
        if (v > N_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -N_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/ttcs_screen.sv @@
module ttcs_screen
    import ttcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_axis,
    input  logic signed [T_W-1:0] i_t,
    input  logic [SZ_W-1:0]       i_size,
    output logic signed [15:0]    o_s
);

    logic [IS_W-1:0]        isz;
    logic [RC_W-1:0]        recip;
    logic signed [T_W+IS_W:0] tw;
    logic signed [T_W+IS_W:0] twb;
    logic signed [T_W+IS_W:0] qf;
    logic signed [N_W-1:0]  n_n;
    logic [N_W-1:0]         n_a;
    logic [RC_W-1:0]        qe;
    logic [RC_W+IS_W-1:0]   back;
    logic [RC_W-1:0]        qc;
    logic [RC_W-1:0]        mag;
    logic signed [N_W-1:0]  sv;

    logic signed [Q_W-1:0]  r_q;
    logic signed [N_W-1:0]  r_n;
    logic                   r_neg;
    logic [N_W-1:0]         r_a;
    logic [N_W+RC_W-1:0]    r_prod;
    logic signed [15:0]     r_s;

    always_comb begin
        isz   = (i_axis == AXIS_Y) ? ISZ_Y : ISZ_X;
        recip = (i_axis == AXIS_Y) ? RECIP_Y : RECIP_X;
        tw    = (T_W+IS_W+1)'(i_t) * $signed({1'b0, isz});
        twb   = tw + (tw[T_W+IS_W] ? (T_W+IS_W+1)'(131071) : '0);
        qf    = twb >>> 17;
        n_n   = N_W'(r_q) * N_W'($signed({1'b0, i_size}))
              + N_W'($signed({1'b0, isz})) * N_W'($signed({1'b0, i_size[SZ_W-1:1]}));
        n_a   = r_n[N_W-1] ? N_W'(-r_n) : N_W'(r_n);
        qe    = r_prod[N_W+RC_W-1:N_W];
        back  = qe * {{(RC_W-IS_W){1'b0}}, isz};
        qc    = (back > (RC_W+IS_W)'(r_a)) ? qe - 1'b1 : qe;
        mag   = qc & ~RC_W'(SNAP_STEP - 1);
        sv    = r_neg ? -N_W'(mag) : N_W'(mag);
    end

    always_ff @(posedge i_clk) begin
        r_q    <= qf[Q_W-1:0];
        r_n    <= n_n;
        r_neg  <= r_n[N_W-1];
        r_a    <= n_a;
        r_prod <= n_a * recip;
        r_s    <= sat16(sv);
    end

    assign o_s = r_s;

endmodule

@@ rtl/core/ttcs_lane.sv @@
module ttcs_lane
    import ttcs_pkg::*;
(
    input  logic               i_clk,
    input  logic [63:0]        i_row_x,
    input  logic [63:0]        i_row_y,
    input  logic [63:0]        i_row_z,
    input  logic [SZ_W-1:0]    i_width,
    input  logic [SZ_W-1:0]    i_height,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_z,
    output t_vtx_xy            o_t,
    output logic signed [15:0] o_sx,
    output logic signed [15:0] o_sy,
    output logic signed [15:0] o_sz
);

    logic [63:0]        rows [3];
    logic signed [31:0] r_p [3][3];
    logic signed [15:0] r_m3 [3];
    logic signed [T_W-1:0] r_t [3];
    logic signed [15:0] r_z [4];
    logic signed [34:0] acc [3];
    logic signed [34:0] accb [3];
    logic signed [34:0] tq [3];

    assign rows[0] = i_row_x;
    assign rows[1] = i_row_y;
    assign rows[2] = i_row_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r]  = 35'(r_p[r][0]) + 35'(r_p[r][1]) + 35'(r_p[r][2])
                    + (35'(r_m3[r]) <<< 12);
            accb[r] = acc[r] + (acc[r][34] ? 35'(4095) : '0);
            tq[r]   = accb[r] >>> 12;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_p[r][0] <= $signed(rows[r][15:0])  * i_x;
            r_p[r][1] <= $signed(rows[r][31:16]) * i_y;
            r_p[r][2] <= $signed(rows[r][47:32]) * i_z;
            r_m3[r]   <= $signed(rows[r][63:48]);
            r_t[r]    <= tq[r][T_W-1:0];
        end
        r_z[0] <= sat16(N_W'(r_t[2]));
        for (int k = 1; k < 4; k++) begin
            r_z[k] <= r_z[k-1];
        end
    end

    ttcs_screen u_scr_x (
        .i_clk  (i_clk),
        .i_axis (AXIS_X),
        .i_t    (r_t[0]),
        .i_size (i_width),
        .o_s    (o_sx)
    );

    ttcs_screen u_scr_y (
        .i_clk  (i_clk),
        .i_axis (AXIS_Y),
        .i_t    (r_t[1]),
        .i_size (i_height),
        .o_s    (o_sy)
    );

    assign o_t.tx = r_t[0];
    assign o_t.ty = r_t[1];
    assign o_sz   = r_z[3];

endmodule

@@ rtl/core/ttcs_merge.sv @@
module ttcs_merge
    import ttcs_pkg::*;
(
    input  logic    i_clk,
    input  t_vtx_xy i_a,
    input  t_vtx_xy i_b,
    input  t_vtx_xy i_c,
    output logic    o_visible
);

    logic signed [T_W:0]     r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [2*T_W+1:0] r_pa, r_pb;
    logic signed [2*T_W+2:0] nz;
    logic                    r_vis0, r_vis1;

    assign nz = (2*T_W+3)'(r_pa) - (2*T_W+3)'(r_pb);

    always_ff @(posedge i_clk) begin
        r_e1x  <= (T_W+1)'(i_b.tx) - (T_W+1)'(i_a.tx);
        r_e1y  <= (T_W+1)'(i_b.ty) - (T_W+1)'(i_a.ty);
        r_e2x  <= (T_W+1)'(i_c.tx) - (T_W+1)'(i_a.tx);
        r_e2y  <= (T_W+1)'(i_c.ty) - (T_W+1)'(i_a.ty);
        r_pa   <= r_e1x * r_e2y;
        r_pb   <= r_e1y * r_e2x;
        r_vis0 <= nz > 0;
        r_vis1 <= r_vis0;
    end

    assign o_visible = r_vis1;

endmodule

@@ rtl/core/triangle_transform_cull_snap.sv @@
// Start shifts through a registered valid pipeline that raises the result strobe.
// Throughput: one triangle per cycle; busy never rises, three vertex lanes
// with multiply stages plus a cross-product merge run fully pipelined.
// Reset (synchronous, active low) clears the strobe pipeline and loads the
// identity matrix and a 640x480 screen. The receiver cannot stall.
`include "triangle_transform_cull_snap_defines.svh"

module triangle_transform_cull_snap
    import ttcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_tri_in     i_tri,
    output logic        o_strobe,
    output t_tri_out    o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [63:0]     r_row_x, r_row_y, r_row_z;
    logic [SZ_W-1:0] r_width, r_height;
    logic [LAT-1:0]  r_vld;
    logic [23:0]     r_rgb [LAT];
    t_vtx_xy         ta, tb, tc;
    logic            accept;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x  <= 64'h0000_0000_0000_1000;
            r_row_y  <= 64'h0000_0000_1000_0000;
            r_row_z  <= 64'h0000_1000_0000_0000;
            r_width  <= SZ_W'(640);
            r_height <= SZ_W'(480);
            r_vld    <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_ROW_X:  r_row_x  <= i_cfg_data;
                    REG_ROW_Y:  r_row_y  <= i_cfg_data;
                    REG_ROW_Z:  r_row_z  <= i_cfg_data;
                    REG_WIDTH:  r_width  <= i_cfg_data[SZ_W-1:0];
                    REG_HEIGHT: r_height <= i_cfg_data[SZ_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb[0] <= i_tri.rgb_in & RGB_MASK;
        for (int k = 1; k < LAT; k++) begin
            r_rgb[k] <= r_rgb[k-1];
        end
    end

    ttcs_lane u_lane_a (
        .i_clk(i_clk), .i_row_x(r_row_x), .i_row_y(r_row_y), .i_row_z(r_row_z),
        .i_width(r_width), .i_height(r_height),
        .i_x(i_tri.a_x), .i_y(i_tri.a_y), .i_z(i_tri.a_z),
        .o_t(ta), .o_sx(o_res.sa_x), .o_sy(o_res.sa_y), .o_sz(o_res.sa_z)
    );

    ttcs_lane u_lane_b (
        .i_clk(i_clk), .i_row_x(r_row_x), .i_row_y(r_row_y), .i_row_z(r_row_z),
        .i_width(r_width), .i_height(r_height),
        .i_x(i_tri.b_x), .i_y(i_tri.b_y), .i_z(i_tri.b_z),
        .o_t(tb), .o_sx(o_res.sb_x), .o_sy(o_res.sb_y), .o_sz(o_res.sb_z)
    );

    ttcs_lane u_lane_c (
        .i_clk(i_clk), .i_row_x(r_row_x), .i_row_y(r_row_y), .i_row_z(r_row_z),
        .i_width(r_width), .i_height(r_height),
        .i_x(i_tri.c_x), .i_y(i_tri.c_y), .i_z(i_tri.c_z),
        .o_t(tc), .o_sx(o_res.sc_x), .o_sy(o_res.sc_y), .o_sz(o_res.sc_z)
    );

    ttcs_merge u_merge (
        .i_clk     (i_clk),
        .i_a       (ta),
        .i_b       (tb),
        .i_c       (tc),
        .o_visible (o_res.visible)
    );

    assign o_res.rgb_out = r_rgb[LAT-1];
    assign o_strobe      = r_vld[LAT-1];

    `TTCS_ASSERT_NOW(a_strobe_from_start, o_strobe, $past(accept, LAT))
    `TTCS_ASSERT_NOW(a_start_gives_strobe, accept, ##LAT o_strobe)
    `TTCS_ASSERT_NEXT(a_rgb_low_clear, o_strobe, $past(o_res.rgb_out & ~RGB_MASK) == 24'h0)

endmodule
